// ===== hdl/pmpe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmpe_pkg
// Shared types and constants for the plus/minus/parenthesis expression
// evaluator.
// ----------------------------------------------------------------------------
package pmpe_pkg;

  localparam int MAX_DEPTH_DEF = 16;
  localparam int VAL_W         = 32;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    ST_OK              = 2'd0,
    ST_TOO_DEEP        = 2'd1,
    ST_UNMATCHED_CLOSE = 2'd2,
    ST_UNCLOSED_OPEN   = 2'd3
  } status_t;

  typedef struct packed {
    logic             neg;
    logic [VAL_W-1:0] sum;
  } frame_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stack_ctrl_t;

endpackage

// ===== hdl/plus_minus_paren_expression_evaluator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plus_minus_paren_expression_evaluator_unit
// Streaming evaluator of +, -, parentheses and decimal integers.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel carries one ASCII character per request; in_last marks
//   the final character of an expression. Digits, '+', '-', '(' and ')'
//   are evaluated, any other byte is ignored.
//   For each request with in_last set, one result appears on the out_
//   channel: out_value (32-bit two's complement, wrapping) and out_status
//   (0 ok, 1 nesting too deep, 2 unmatched close, 3 unclosed open).
//   Throughput is one character per cycle unless stalled. The result is
//   registered and, with the output free, valid the cycle after the last
//   character is accepted. Open frames live in memory, the top frame in
//   registers; a pop prefetches the next frame, so nested parentheses run
//   at full rate. A result waiting under out_stall does not block input:
//   a second result register absorbs one more result, and in_stall rises
//   only when both are full. Reset clears the evaluation state and empties
//   the output registers; stack memory needs no clearing. After each
//   result the state returns to its reset values for the next expression.
// ----------------------------------------------------------------------------
module plus_minus_paren_expression_evaluator_unit #(
  parameter int MAX_DEPTH = pmpe_pkg::MAX_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_character,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_value,
  output logic [1:0]         out_status
);
  import pmpe_pkg::*;

  localparam int LVL_W = $clog2(MAX_DEPTH + 1);

  logic             in_acc;
  logic             is_digit;
  logic             is_sign;
  logic             is_open;
  logic             is_close;
  logic             can_push;
  logic             can_pop;
  logic [VAL_W-1:0] digit_val;
  logic [VAL_W-1:0] folded;

  logic [VAL_W-1:0] sum_r,  sum_nxt;
  logic [VAL_W-1:0] cur_r,  cur_nxt;
  logic             neg_r,  neg_nxt;
  logic [LVL_W-1:0] lvl_r,  lvl_nxt;
  status_t          err_r,  err_nxt;

  logic [VAL_W-1:0] res_value;
  status_t          res_status;
  logic             res_valid;

  logic             out_valid_r;
  logic [VAL_W-1:0] out_value_r;
  status_t          out_status_r;
  logic             skid_valid_r;
  logic [VAL_W-1:0] skid_value_r;
  status_t          skid_status_r;
  logic             out_take;

  stack_ctrl_t      stk_ctrl;
  frame_t           push_frame;
  frame_t           top_frame;

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !in_stall;

  assign is_digit = (in_character >= CH_ZERO) && (in_character <= CH_NINE);
  assign is_sign  = (in_character == CH_PLUS) || (in_character == CH_MINUS);
  assign is_open  = (in_character == CH_OPEN);
  assign is_close = (in_character == CH_CLOSE);
  assign can_push = lvl_r < LVL_W'(MAX_DEPTH);
  assign can_pop  = lvl_r != '0;

  assign digit_val = VAL_W'(in_character[3:0]);
  assign folded    = neg_r ? (sum_r - cur_r) : (sum_r + cur_r);

  assign stk_ctrl.push = in_acc && is_open && can_push;
  assign stk_ctrl.pop  = in_acc && is_close && can_pop;
  assign push_frame.neg = neg_r;
  assign push_frame.sum = sum_r;

  pmpe_stack #(
    .MAX_DEPTH (MAX_DEPTH),
    .LVL_W     (LVL_W)
  ) u_stack (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (stk_ctrl),
    .level      (lvl_r),
    .push_frame (push_frame),
    .top_frame  (top_frame)
  );

  always_comb begin
    sum_nxt = sum_r;
    cur_nxt = cur_r;
    neg_nxt = neg_r;
    lvl_nxt = lvl_r;
    err_nxt = err_r;
    if (is_digit) begin
      cur_nxt = {cur_r[VAL_W-4:0], 3'b000} + {cur_r[VAL_W-2:0], 1'b0} + digit_val;
    end else if (is_sign) begin
      sum_nxt = folded;
      cur_nxt = '0;
      neg_nxt = (in_character == CH_MINUS);
    end else if (is_open) begin
      if (can_push) begin
        lvl_nxt = lvl_r + LVL_W'(1);
        sum_nxt = '0;
        cur_nxt = '0;
        neg_nxt = 1'b0;
      end else if (err_r == ST_OK) begin
        err_nxt = ST_TOO_DEEP;
      end
    end else if (is_close) begin
      cur_nxt = '0;
      if (can_pop) begin
        lvl_nxt = lvl_r - LVL_W'(1);
        sum_nxt = top_frame.neg ? (top_frame.sum - folded) : (top_frame.sum + folded);
        neg_nxt = 1'b0;
      end else begin
        sum_nxt = folded;
        if (err_r == ST_OK) begin
          err_nxt = ST_UNMATCHED_CLOSE;
        end
      end
    end
  end

  always_comb begin
    res_valid = in_acc && in_last;
    res_value = neg_nxt ? (sum_nxt - cur_nxt) : (sum_nxt + cur_nxt);
    if (err_nxt != ST_OK) begin
      res_status = err_nxt;
    end else if (lvl_nxt != '0) begin
      res_status = ST_UNCLOSED_OPEN;
    end else begin
      res_status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cur_r <= '0;
      neg_r <= 1'b0;
      lvl_r <= '0;
      err_r <= ST_OK;
    end else if (in_acc) begin
      if (in_last) begin
        sum_r <= '0;
        cur_r <= '0;
        neg_r <= 1'b0;
        lvl_r <= '0;
        err_r <= ST_OK;
      end else begin
        sum_r <= sum_nxt;
        cur_r <= cur_nxt;
        neg_r <= neg_nxt;
        lvl_r <= lvl_nxt;
        err_r <= err_nxt;
      end
    end
  end

  // output register plus skid register
  assign out_take = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (res_valid) begin
      if (out_valid_r && !out_take) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_value_r  <= skid_value_r;
        out_status_r <= skid_status_r;
      end
    end else if (res_valid) begin
      if (out_valid_r && !out_take) begin
        skid_value_r  <= res_value;
        skid_status_r <= res_status;
      end else begin
        out_value_r  <= res_value;
        out_status_r <= res_status;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register full while output register empty");

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    lvl_r <= LVL_W'(MAX_DEPTH))
    else $error("nesting level above maximum depth");

  a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_last) |=> out_valid_r)
    else $error("last character produced no result");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_last) |=> (lvl_r == '0 && err_r == ST_OK && cur_r == '0))
    else $error("state not cleared after expression end");

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_last && err_r != ST_OK) |=> $stable(err_r))
    else $error("first error overwritten");

endmodule

// ===== hdl/pmpe_stack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmpe_stack
// Frame stack: top frame held in registers, older frames in a synchronous
// memory. A pop prefetches the next frame.
// ----------------------------------------------------------------------------
module pmpe_stack #(
  parameter int MAX_DEPTH = pmpe_pkg::MAX_DEPTH_DEF,
  parameter int LVL_W     = $clog2(MAX_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pmpe_pkg::stack_ctrl_t ctrl,
  input  logic [LVL_W-1:0]    level,
  input  pmpe_pkg::frame_t    push_frame,
  output pmpe_pkg::frame_t    top_frame
);
  import pmpe_pkg::*;

  localparam int ADDR_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  frame_t             mem [MAX_DEPTH];
  frame_t             rd_data_r;
  frame_t             top_r;
  frame_t             top_nxt;
  logic               from_mem_r;
  logic               from_mem_nxt;
  logic [LVL_W-1:0]   wr_lvl;
  logic [LVL_W-1:0]   rd_lvl;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ADDR_W-1:0]  rd_addr;
  logic               mem_wr;

  assign top_frame = from_mem_r ? rd_data_r : top_r;

  assign wr_lvl  = level - LVL_W'(1);
  assign rd_lvl  = level - LVL_W'(2);
  assign wr_addr = wr_lvl[ADDR_W-1:0];
  assign rd_addr = rd_lvl[ADDR_W-1:0];
  assign mem_wr  = ctrl.push && (level != '0);

  always_comb begin
    top_nxt      = top_frame;
    from_mem_nxt = 1'b0;
    if (ctrl.push) begin
      top_nxt = push_frame;
    end else if (ctrl.pop) begin
      from_mem_nxt = 1'b1;
    end
  end

  // old top spills to memory on push
  always_ff @(posedge clk) begin
    if (mem_wr) begin
      mem[wr_addr] <= top_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push || ctrl.pop) begin
      top_r <= top_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      from_mem_r <= 1'b0;
    end else if (ctrl.push || ctrl.pop) begin
      from_mem_r <= from_mem_nxt;
    end
  end

  a_no_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctrl.push && ctrl.pop))
    else $error("push and pop in the same cycle");

  a_pop_prefetch: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.pop |=> from_mem_r)
    else $error("pop did not select prefetched frame");

  a_push_reg: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.push |=> !from_mem_r)
    else $error("push did not select register frame");

endmodule
